>>> sv/imrb_pkg.sv
// Package: register map, operation and status codes for the interrupt/mode register block.
package imrb_pkg;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_RAISE = 2'd2,
        FUNC_CLEAR = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_SIZE = 2'd1,
        STATUS_BAD_ADDR = 2'd2
    } t_status;

    localparam logic [31:0] ADDR_MODE    = 32'h0430_0000;
    localparam logic [31:0] ADDR_VERSION = 32'h0430_0004;
    localparam logic [31:0] ADDR_FLAGS   = 32'h0430_0008;
    localparam logic [31:0] ADDR_MASK    = 32'h0430_000c;

    localparam logic [3:0] GOOD_SIZE = 4'd4;

    localparam int unsigned NUM_SOURCES = 6;
    localparam int unsigned MODE_WIDTH  = 10;
    localparam int unsigned LEN_WIDTH   = 7;

    // mode word bit positions
    localparam int unsigned MODE_INIT_BIT  = 7;
    localparam int unsigned MODE_EBUS_BIT  = 8;
    localparam int unsigned MODE_RDRAM_BIT = 9;

    // mode write command bits
    localparam int unsigned WR_CLR_INIT  = 7;
    localparam int unsigned WR_SET_INIT  = 8;
    localparam int unsigned WR_CLR_EBUS  = 9;
    localparam int unsigned WR_SET_EBUS  = 10;
    localparam int unsigned WR_CLR_DP    = 11;
    localparam int unsigned WR_CLR_RDRAM = 12;
    localparam int unsigned WR_SET_RDRAM = 13;

    // source flag of the display unit
    localparam int unsigned DP_BIT = 5;

    // config register byte offsets
    localparam logic [2:0] CFG_VERSION = 3'd0;

endpackage

>>> sv/imrb_in_if.sv
// Interface: request channel into the interrupt/mode register block.
interface imrb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [3:0]  access_size;
    logic [31:0] bus_address;
    logic [31:0] write_data;
    logic [5:0]  source_bits;

    modport source (
        output valid, func, access_size, bus_address, write_data, source_bits,
        input  ready
    );
    modport sink (
        input  valid, func, access_size, bus_address, write_data, source_bits,
        output ready
    );
endinterface

>>> sv/imrb_out_if.sv
// Interface: result channel out of the interrupt/mode register block.
interface imrb_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [1:0]  status;
    logic        interrupt_line;

    modport source (
        output valid, read_data, status, interrupt_line,
        input  ready
    );
    modport sink (
        input  valid, read_data, status, interrupt_line,
        output ready
    );
endinterface

>>> sv/interrupt_mode_register_block_top.sv
// Top level: interrupt/mode register block with request/result channels and APB config port.
//
//   channel   | dir | handshake        | payload
//   ----------+-----+------------------+----------------------------------------------
//   i_in      | in  | valid/ready      | func, access_size, bus_address, write_data,
//             |     |                  | source_bits
//   o_out     | out | valid/ready      | read_data, status, interrupt_line
//   apb       | in  | psel/penable     | paddr[2:0], pwdata, prdata (version word)
//
// A request is captured in an input register, decoded against the state, and its result
// lands in the output register; one request per cycle is sustained while o_out.ready
// stays high. State updates as a request moves from the input to the output
// register. When the result is not taken, the input register still accepts one more
// request, then i_in.ready drops. Reset (i_rst_n low, synchronous) clears mode, flags,
// mask, version and both valid bits.
module interrupt_mode_register_block_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    imrb_in_if.sink     i_in,
    imrb_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned NS = imrb_pkg::NUM_SOURCES;
    localparam int unsigned MW = imrb_pkg::MODE_WIDTH;
    localparam int unsigned LW = imrb_pkg::LEN_WIDTH;

    logic [31:0]   r_version;
    logic [MW-1:0] r_mode;
    logic [NS-1:0] r_flags;
    logic [NS-1:0] r_mask;

    logic          r_in_valid;
    logic [1:0]    r_in_func;
    logic [3:0]    r_in_size;
    logic [31:0]   r_in_addr;
    logic [31:0]   r_in_data;
    logic [NS-1:0] r_in_bits;

    logic          r_out_valid;
    logic [31:0]   r_out_rd;
    logic [1:0]    r_out_st;
    logic          r_out_irq;

    logic [MW-1:0] n_mode;
    logic [NS-1:0] n_flags;
    logic [NS-1:0] n_mask;
    logic [31:0]   n_rd;
    logic [1:0]    n_st;

    logic          advance;
    logic          in_take;
    logic          cfg_wr;

    assign advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_take  = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || advance;

    assign o_out.valid          = r_out_valid;
    assign o_out.read_data      = r_out_rd;
    assign o_out.status         = r_out_st;
    assign o_out.interrupt_line = r_out_irq;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == imrb_pkg::CFG_VERSION[2]);
    assign prdata = (paddr[2] == imrb_pkg::CFG_VERSION[2]) ? r_version : 32'd0;

    always_comb begin
        n_mode  = r_mode;
        n_flags = r_flags;
        n_mask  = r_mask;
        n_rd    = 32'd0;
        n_st    = imrb_pkg::STATUS_OK;
        unique case (imrb_pkg::t_func'(r_in_func))
            imrb_pkg::FUNC_RAISE: begin
                n_flags = r_flags | r_in_bits;
            end
            imrb_pkg::FUNC_CLEAR: begin
                n_flags = r_flags & ~r_in_bits;
            end
            imrb_pkg::FUNC_READ: begin
                if (r_in_size != imrb_pkg::GOOD_SIZE) begin
                    n_st = imrb_pkg::STATUS_BAD_SIZE;
                end else begin
                    unique case (r_in_addr)
                        imrb_pkg::ADDR_MODE:    n_rd = {{(32-MW){1'b0}}, r_mode};
                        imrb_pkg::ADDR_VERSION: n_rd = r_version;
                        imrb_pkg::ADDR_FLAGS:   n_rd = {{(32-NS){1'b0}}, r_flags};
                        imrb_pkg::ADDR_MASK:    n_rd = {{(32-NS){1'b0}}, r_mask};
                        default:                n_st = imrb_pkg::STATUS_BAD_ADDR;
                    endcase
                end
            end
            imrb_pkg::FUNC_WRITE: begin
                if (r_in_size != imrb_pkg::GOOD_SIZE) begin
                    n_st = imrb_pkg::STATUS_BAD_SIZE;
                end else begin
                    unique case (r_in_addr)
                        imrb_pkg::ADDR_MODE: begin
                            // length is replaced; flags take clear then set
                            n_mode[LW-1:0] = r_in_data[LW-1:0];
                            if (r_in_data[imrb_pkg::WR_CLR_INIT])
                                n_mode[imrb_pkg::MODE_INIT_BIT] = 1'b0;
                            if (r_in_data[imrb_pkg::WR_SET_INIT])
                                n_mode[imrb_pkg::MODE_INIT_BIT] = 1'b1;
                            if (r_in_data[imrb_pkg::WR_CLR_EBUS])
                                n_mode[imrb_pkg::MODE_EBUS_BIT] = 1'b0;
                            if (r_in_data[imrb_pkg::WR_SET_EBUS])
                                n_mode[imrb_pkg::MODE_EBUS_BIT] = 1'b1;
                            if (r_in_data[imrb_pkg::WR_CLR_DP])
                                n_flags[imrb_pkg::DP_BIT] = 1'b0;
                            if (r_in_data[imrb_pkg::WR_CLR_RDRAM])
                                n_mode[imrb_pkg::MODE_RDRAM_BIT] = 1'b0;
                            if (r_in_data[imrb_pkg::WR_SET_RDRAM])
                                n_mode[imrb_pkg::MODE_RDRAM_BIT] = 1'b1;
                        end
                        imrb_pkg::ADDR_MASK: begin
                            for (int i = 0; i < NS; i++) begin
                                if (r_in_data[2*i])
                                    n_mask[i] = 1'b0;
                                if (r_in_data[2*i+1])
                                    n_mask[i] = 1'b1;
                            end
                        end
                        imrb_pkg::ADDR_VERSION, imrb_pkg::ADDR_FLAGS: begin
                            // read-only targets, write dropped
                        end
                        default: n_st = imrb_pkg::STATUS_BAD_ADDR;
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version   <= 32'd0;
            r_mode      <= '0;
            r_flags     <= '0;
            r_mask      <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr)
                r_version <= pwdata;

            if (in_take)
                r_in_valid <= 1'b1;
            else if (advance)
                r_in_valid <= 1'b0;

            if (advance) begin
                r_mode      <= n_mode;
                r_flags     <= n_flags;
                r_mask      <= n_mask;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_func <= i_in.func;
            r_in_size <= i_in.access_size;
            r_in_addr <= i_in.bus_address;
            r_in_data <= i_in.write_data;
            r_in_bits <= i_in.source_bits;
        end
        if (advance) begin
            r_out_rd  <= n_rd;
            r_out_st  <= n_st;
            r_out_irq <= |(n_flags & n_mask);
        end
    end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the interrupt/mode register block: directed and random requests.
module testbench;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned DRAIN_CYCLES = 6;

    typedef struct {
        imrb_pkg::t_func func;
        logic [3:0]      size;
        logic [31:0]     addr;
        logic [31:0]     data;
        logic [5:0]      bits;
    } t_bus_request;

    typedef struct {
        logic [31:0]       read_data;
        imrb_pkg::t_status status;
        logic              irq;
    } t_bus_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    imrb_in_if  in_if ();
    imrb_out_if out_if ();

    interrupt_mode_register_block_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the block state
    logic [31:0] version_q;
    logic [9:0]  mode_q;
    logic [5:0]  flags_q;
    logic [5:0]  mask_q;

    t_bus_reply  expected_replies[$];
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_rx = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned requests_sent = 0;
    int unsigned replies_checked = 0;
    int unsigned version_writes = 0;
    int unsigned mismatches = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, expected_replies.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // result side: random stalls, or a forced hold-off
    always @(posedge i_clk) begin
        out_if.ready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_bus_reply exp;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_replies.size() == 0) begin
                $error("unexpected reply: read_data=%h status=%0d irq=%0b",
                       out_if.read_data, out_if.status, out_if.interrupt_line);
                mismatches++;
            end else begin
                exp = expected_replies.pop_front();
                replies_checked++;
                if (out_if.read_data !== exp.read_data) begin
                    $error("read_data: expected %h, got %h", exp.read_data, out_if.read_data);
                    mismatches++;
                end
                if (out_if.status !== exp.status) begin
                    $error("status: expected %0d, got %0d", exp.status, out_if.status);
                    mismatches++;
                end
                if (out_if.interrupt_line !== exp.irq) begin
                    $error("interrupt_line: expected %0b, got %0b", exp.irq,
                           out_if.interrupt_line);
                    mismatches++;
                end
            end
        end
    end

    function automatic t_bus_reply predict_access(input t_bus_request r);
        t_bus_reply e;
        logic [9:0] m;
        e.read_data = '0;
        e.status    = imrb_pkg::STATUS_OK;
        e.irq       = 1'b0;
        if (r.func == imrb_pkg::FUNC_RAISE) begin
            flags_q = flags_q | r.bits;
        end else if (r.func == imrb_pkg::FUNC_CLEAR) begin
            flags_q = flags_q & ~r.bits;
        end else if (r.size != imrb_pkg::GOOD_SIZE) begin
            e.status = imrb_pkg::STATUS_BAD_SIZE;
        end else if (r.func == imrb_pkg::FUNC_READ) begin
            case (r.addr)
                imrb_pkg::ADDR_MODE:    e.read_data = 32'(mode_q);
                imrb_pkg::ADDR_VERSION: e.read_data = version_q;
                imrb_pkg::ADDR_FLAGS:   e.read_data = 32'(flags_q);
                imrb_pkg::ADDR_MASK:    e.read_data = 32'(mask_q);
                default:                e.status = imrb_pkg::STATUS_BAD_ADDR;
            endcase
        end else begin
            case (r.addr)
                imrb_pkg::ADDR_MODE: begin
                    // clear first, then set: set wins
                    m = {mode_q[9:imrb_pkg::LEN_WIDTH], r.data[imrb_pkg::LEN_WIDTH-1:0]};
                    if (r.data[imrb_pkg::WR_CLR_INIT])  m[imrb_pkg::MODE_INIT_BIT] = 1'b0;
                    if (r.data[imrb_pkg::WR_SET_INIT])  m[imrb_pkg::MODE_INIT_BIT] = 1'b1;
                    if (r.data[imrb_pkg::WR_CLR_EBUS])  m[imrb_pkg::MODE_EBUS_BIT] = 1'b0;
                    if (r.data[imrb_pkg::WR_SET_EBUS])  m[imrb_pkg::MODE_EBUS_BIT] = 1'b1;
                    if (r.data[imrb_pkg::WR_CLR_DP])    flags_q[imrb_pkg::DP_BIT]   = 1'b0;
                    if (r.data[imrb_pkg::WR_CLR_RDRAM]) m[imrb_pkg::MODE_RDRAM_BIT] = 1'b0;
                    if (r.data[imrb_pkg::WR_SET_RDRAM]) m[imrb_pkg::MODE_RDRAM_BIT] = 1'b1;
                    mode_q = m;
                end
                imrb_pkg::ADDR_MASK: begin
                    for (int i = 0; i < imrb_pkg::NUM_SOURCES; i++) begin
                        if (r.data[2*i])     mask_q[i] = 1'b0;
                        if (r.data[2*i + 1]) mask_q[i] = 1'b1;
                    end
                end
                imrb_pkg::ADDR_VERSION, imrb_pkg::ADDR_FLAGS: ;
                default: e.status = imrb_pkg::STATUS_BAD_ADDR;
            endcase
        end
        e.irq = |(flags_q & mask_q);
        return e;
    endfunction

    function automatic t_bus_request make_request(input imrb_pkg::t_func f,
                                                  input logic [3:0] size,
                                                  input logic [31:0] addr,
                                                  input logic [31:0] data,
                                                  input logic [5:0] bits);
        t_bus_request r;
        r.func = f;
        r.size = size;
        r.addr = addr;
        r.data = data;
        r.bits = bits;
        return r;
    endfunction

    function automatic t_bus_request random_request();
        t_bus_request r;
        int unsigned  pick;
        pick   = $urandom_range(99);
        r.func = pick < 35 ? imrb_pkg::FUNC_READ : pick < 70 ? imrb_pkg::FUNC_WRITE :
                 pick < 85 ? imrb_pkg::FUNC_RAISE : imrb_pkg::FUNC_CLEAR;
        r.size = ($urandom_range(99) < 85) ? imrb_pkg::GOOD_SIZE : 4'($urandom_range(15));
        pick   = $urandom_range(9);
        if (pick < 8)
            r.addr = imrb_pkg::ADDR_MODE + 32'(4 * $urandom_range(3));
        else if (pick == 8)
            r.addr = $urandom;
        else
            r.addr = imrb_pkg::ADDR_MODE ^ (32'd1 << $urandom_range(31));  // near miss
        r.data = $urandom;
        r.bits = 6'($urandom);
        return r;
    endfunction

    // valid stays high when the next request follows without a gap
    task automatic send_request(input t_bus_request r);
        in_if.valid       <= 1'b1;
        in_if.func        <= r.func;
        in_if.access_size <= r.size;
        in_if.bus_address <= r.addr;
        in_if.write_data  <= r.data;
        in_if.source_bits <= r.bits;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        expected_replies.push_back(predict_access(r));
        requests_sent++;
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain_replies();
        in_if.valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write the version word, then read it back over the config port
    task automatic write_version(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= imrb_pkg::CFG_VERSION;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== value) begin
            $error("prdata: expected %h, got %h", value, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        version_q = value;
        version_writes++;
    endtask

    task automatic test_reset_state();
        send_request(make_request(imrb_pkg::FUNC_READ, imrb_pkg::GOOD_SIZE,
                                  imrb_pkg::ADDR_MODE, '0, '0));
        send_request(make_request(imrb_pkg::FUNC_READ, imrb_pkg::GOOD_SIZE,
                                  imrb_pkg::ADDR_VERSION, '0, '0));
        send_request(make_request(imrb_pkg::FUNC_READ, imrb_pkg::GOOD_SIZE,
                                  imrb_pkg::ADDR_FLAGS, '0, '0));
        send_request(make_request(imrb_pkg::FUNC_READ, imrb_pkg::GOOD_SIZE,
                                  imrb_pkg::ADDR_MASK, '0, '0));
        drain_replies();
    endtask

    task automatic test_version_register();
        write_version(32'hffff_ffff);
        send_request(make_request(imrb_pkg::FUNC_READ, imrb_pkg::GOOD_SIZE,
                                  imrb_pkg::ADDR_VERSION, '0, '0));
        // bus write to version is ignored
        send_request(make_request(imrb_pkg::FUNC_WRITE, imrb_pkg::GOOD_SIZE,
                                  imrb_pkg::ADDR_VERSION, '0, '0));
        send_request(make_request(imrb_pkg::FUNC_READ, imrb_pkg::GOOD_SIZE,
                                  imrb_pkg::ADDR_VERSION, '0, '0));
    endtask

    task automatic test_mode_writes();
        // every clear/set pair given at once, max init length
        send_request(make_request(imrb_pkg::FUNC_WRITE, imrb_pkg::GOOD_SIZE,
                                  imrb_pkg::ADDR_MODE, 32'hffff_ffff, '0));
        send_request(make_request(imrb_pkg::FUNC_READ, imrb_pkg::GOOD_SIZE,
                                  imrb_pkg::ADDR_MODE, '0, '0));
        send_request(make_request(imrb_pkg::FUNC_WRITE, imrb_pkg::GOOD_SIZE,
                                  imrb_pkg::ADDR_MODE,
                                  (32'd1 << imrb_pkg::WR_CLR_INIT) |
                                  (32'd1 << imrb_pkg::WR_CLR_EBUS) |
                                  (32'd1 << imrb_pkg::WR_CLR_RDRAM), '0));
        send_request(make_request(imrb_pkg::FUNC_READ, imrb_pkg::GOOD_SIZE,
                                  imrb_pkg::ADDR_MODE, '0, '0));
    endtask

    task automatic test_mask_and_line();
        send_request(make_request(imrb_pkg::FUNC_WRITE, imrb_pkg::GOOD_SIZE,
                                  imrb_pkg::ADDR_MASK, 32'h0000_0fff, '0));
        send_request(make_request(imrb_pkg::FUNC_RAISE, imrb_pkg::GOOD_SIZE,
                                  imrb_pkg::ADDR_MODE, '0, 6'h3f));
        send_request(make_request(imrb_pkg::FUNC_WRITE, imrb_pkg::GOOD_SIZE,
                                  imrb_pkg::ADDR_MODE, 32'd1 << imrb_pkg::WR_CLR_DP, '0));
        send_request(make_request(imrb_pkg::FUNC_READ, imrb_pkg::GOOD_SIZE,
                                  imrb_pkg::ADDR_FLAGS, '0, '0));
        send_request(make_request(imrb_pkg::FUNC_CLEAR, imrb_pkg::GOOD_SIZE,
                                  imrb_pkg::ADDR_MODE, '0, 6'h1f));
        // even bits clear every mask bit
        send_request(make_request(imrb_pkg::FUNC_WRITE, imrb_pkg::GOOD_SIZE,
                                  imrb_pkg::ADDR_MASK, 32'h0000_0555, '0));
        send_request(make_request(imrb_pkg::FUNC_READ, imrb_pkg::GOOD_SIZE,
                                  imrb_pkg::ADDR_MASK, '0, '0));
    endtask

    task automatic test_access_errors();
        send_request(make_request(imrb_pkg::FUNC_READ, 4'd0, imrb_pkg::ADDR_MODE, '0, '0));
        send_request(make_request(imrb_pkg::FUNC_WRITE, 4'hf, 32'hffff_ffff,
                                  32'hffff_ffff, '0));
        send_request(make_request(imrb_pkg::FUNC_READ, 4'd8, imrb_pkg::ADDR_MASK, '0, '0));
        send_request(make_request(imrb_pkg::FUNC_READ, imrb_pkg::GOOD_SIZE,
                                  32'hffff_ffff, '0, '0));
        send_request(make_request(imrb_pkg::FUNC_WRITE, imrb_pkg::GOOD_SIZE,
                                  32'h0000_0000, 32'hffff_ffff, '0));
        send_request(make_request(imrb_pkg::FUNC_WRITE, imrb_pkg::GOOD_SIZE,
                                  imrb_pkg::ADDR_FLAGS, 32'hffff_ffff, '0));
        // raise ignores size, address and data
        send_request(make_request(imrb_pkg::FUNC_RAISE, 4'd0, 32'hffff_ffff,
                                  32'hffff_ffff, 6'h2a));
        drain_replies();
    endtask

    task automatic test_random_traffic(input int unsigned count, input int unsigned send_pct,
                                       input int unsigned recv_pct,
                                       input logic [31:0] version);
        write_version(version);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) send_request(random_request());
        drain_replies();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_rx <= 1'b1;
                repeat (60) @(posedge i_clk);
                hold_rx <= 1'b0;
            end
        join_none
        repeat (30) send_request(random_request());
        // sender waits for every reply before going on
        drain_replies();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_if.valid       = 1'b0;
        in_if.func        = imrb_pkg::FUNC_READ;
        in_if.access_size = '0;
        in_if.bus_address = '0;
        in_if.write_data  = '0;
        in_if.source_bits = '0;
        out_if.ready      = 1'b0;
        version_q         = '0;
        mode_q            = '0;
        flags_q           = '0;
        mask_q            = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_version_register();
        test_mode_writes();
        test_mask_and_line();
        test_access_errors();
        test_random_traffic(250, 0, 0, 32'h0000_0000);
        test_random_traffic(250, 61, 0, $urandom);
        test_random_traffic(250, 0, 61, 32'hffff_ffff);
        test_random_traffic(250, 12, 12, $urandom);
        test_backpressure();

        $display("covered reads, writes, raises and clears incl. bad sizes and addresses");
        $display("%0d requests, %0d replies checked, %0d version settings, %0d mismatches",
                 requests_sent, replies_checked, version_writes, mismatches);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
